### rtl/voc_pkg.sv
// ----------------------------------------------------------------------------
// voc_pkg
// Shared types and constants of the voxel occupancy counter: register map,
// request codes and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package voc_pkg;

  localparam int PT_W     = 32;  // Q16.16 coordinates and origins
  localparam int CFG_W    = 32;  // widest register
  localparam int DIM_W    = 6;   // grid dimension registers
  localparam int THR_W    = 16;  // min_points register
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register map
  localparam cfg_idx_t REG_ORIGIN_X   = 3'd0;
  localparam cfg_idx_t REG_ORIGIN_Y   = 3'd1;
  localparam cfg_idx_t REG_ORIGIN_Z   = 3'd2;
  localparam cfg_idx_t REG_INV_VOXEL  = 3'd3;
  localparam cfg_idx_t REG_GRID_DIM_X = 3'd4;
  localparam cfg_idx_t REG_GRID_DIM_Y = 3'd5;
  localparam cfg_idx_t REG_GRID_DIM_Z = 3'd6;
  localparam cfg_idx_t REG_MIN_POINTS = 3'd7;

  // request codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // axis select for the shared multiplier
  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  typedef struct packed {
    logic  load;      // take a point from the input port
    logic  mul;       // scale one axis
    logic  chk;       // range check one axis, keep its coordinate
    logic  idx1;      // z*gy + y
    logic  idx2;      // (z*gy + y)*gx + x
    logic  upd;       // write back incremented count, maybe emit
    logic  clr_step;  // zero one store entry
    axis_t axis;
  } voc_cmd_t;

  typedef struct packed {
    logic drop;      // current axis out of range
    logic emit;      // incremented count hits the threshold
    logic out_busy;  // output register full and not taken this cycle
    logic clr_last;  // clearing pass at its last entry
  } voc_sts_t;

endpackage

### rtl/voc_in_if.sv
// ----------------------------------------------------------------------------
// voc_in_if
// Request channel: add a point or clear the count store.
// ----------------------------------------------------------------------------
interface voc_in_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, req_type, point_x, point_y, point_z, input ready);
  modport sink   (input valid, req_type, point_x, point_y, point_z, output ready);
endinterface

### rtl/voc_out_if.sv
// ----------------------------------------------------------------------------
// voc_out_if
// Result channel: one newly occupied voxel per transfer.
// ----------------------------------------------------------------------------
interface voc_out_if #(
  parameter int COORD_W = 5
);
  localparam int IDX_W = 3 * COORD_W;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] voxel_x;
  logic [COORD_W-1:0] voxel_y;
  logic [COORD_W-1:0] voxel_z;
  logic [IDX_W-1:0]   voxel_index;

  modport source (output valid, voxel_x, voxel_y, voxel_z, voxel_index, input ready);
  modport sink   (input valid, voxel_x, voxel_y, voxel_z, voxel_index, output ready);
endinterface

### rtl/voc_ctrl.sv
// ----------------------------------------------------------------------------
// voc_ctrl
// Sequencer: clearing pass, per-axis scaling loop, index build and count
// read-modify-write.
// ----------------------------------------------------------------------------
module voc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_ready,
  input  voc_pkg::voc_sts_t st,
  output voc_pkg::voc_cmd_t cmd
);
  import voc_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_IDX1  = 3'd4;
  localparam logic [2:0] S_IDX2  = 3'd5;
  localparam logic [2:0] S_RD    = 3'd6;
  localparam logic [2:0] S_UPD   = 3'd7;

  logic [2:0] state, state_next;
  axis_t      axis, axis_next;
  logic       in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_CLEAR) begin
            state_next = S_CLEAR;
          end else begin
            cmd.load   = 1'b1;
            axis_next  = AXIS_X;
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        priority if (st.drop) begin
          state_next = S_IDLE;
        end else if (axis == AXIS_Z) begin
          state_next = S_IDX1;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_MUL;
        end
      end
      S_IDX1: begin
        cmd.idx1   = 1'b1;
        state_next = S_IDX2;
      end
      S_IDX2: begin
        cmd.idx2   = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        // hold while a result would land on a full output register
        if (!(st.emit && st.out_busy)) begin
          cmd.upd    = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      axis  <= AXIS_X;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  a_clear_req_starts_pass: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_req_type == REQ_CLEAR) |=> (state == S_CLEAR))
    else $error("clear request did not start a clearing pass");

  a_reset_starts_pass: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> (state == S_CLEAR))
    else $error("reset did not start a clearing pass");

  a_upd_holds_on_full_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && st.emit && st.out_busy) |=> (state == S_UPD))
    else $error("count update went ahead into a full output register");

endmodule

### rtl/voc_dp.sv
// ----------------------------------------------------------------------------
// voc_dp
// Datapath: registers, origin subtract, shared 32x32 scaler, range checks,
// linear index, count store and result register.
// ----------------------------------------------------------------------------
module voc_dp #(
  parameter int MAX_DIM    = 32,
  parameter int COUNT_BITS = 16,
  parameter int COORD_W    = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_we,
  input  voc_pkg::cfg_idx_t          cfg_index,
  input  logic [voc_pkg::CFG_W-1:0]  cfg_data,
  // request payload
  input  logic signed [voc_pkg::PT_W-1:0] point_x,
  input  logic signed [voc_pkg::PT_W-1:0] point_y,
  input  logic signed [voc_pkg::PT_W-1:0] point_z,
  // control
  input  voc_pkg::voc_cmd_t          cmd,
  output voc_pkg::voc_sts_t          st,
  // result
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [COORD_W-1:0]         voxel_x,
  output logic [COORD_W-1:0]         voxel_y,
  output logic [COORD_W-1:0]         voxel_z,
  output logic [3*COORD_W-1:0]       voxel_index
);
  import voc_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = 3 * COORD_W;
  localparam int LIM_W  = COORD_W + 1;
  localparam int TF_W   = 2 * COORD_W + 2;
  localparam int IF_W   = 3 * COORD_W + 2;
  localparam int CMP_W  = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration registers
  logic [PT_W-1:0]  org_x, org_y, org_z;
  logic [CFG_W-1:0] inv_size;
  logic [DIM_W-1:0] grid_dim_x, grid_dim_y, grid_dim_z;
  logic [THR_W-1:0] min_points;

  always_ff @(posedge clk) begin
    if (rst) begin
      org_x      <= '0;
      org_y      <= '0;
      org_z      <= '0;
      inv_size   <= CFG_W'(65536);
      grid_dim_x <= DIM_W'(32);
      grid_dim_y <= DIM_W'(32);
      grid_dim_z <= DIM_W'(32);
      min_points <= THR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:   org_x      <= cfg_data[PT_W-1:0];
        REG_ORIGIN_Y:   org_y      <= cfg_data[PT_W-1:0];
        REG_ORIGIN_Z:   org_z      <= cfg_data[PT_W-1:0];
        REG_INV_VOXEL:  inv_size   <= cfg_data;
        REG_GRID_DIM_X: grid_dim_x <= cfg_data[DIM_W-1:0];
        REG_GRID_DIM_Y: grid_dim_y <= cfg_data[DIM_W-1:0];
        REG_GRID_DIM_Z: grid_dim_z <= cfg_data[DIM_W-1:0];
        REG_MIN_POINTS: min_points <= cfg_data[THR_W-1:0];
      endcase
    end
  end

  // dimension clamped to MAX_DIM
  function automatic logic [LIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] dim);
    logic [LIM_W-1:0] lim;
    if (32'(dim) > 32'(MAX_DIM)) lim = LIM_W'(MAX_DIM);
    else                          lim = LIM_W'(dim);
    return lim;
  endfunction

  logic [LIM_W-1:0] lim_x, lim_y, lim_z;
  assign lim_x = clamp_dim(grid_dim_x);
  assign lim_y = clamp_dim(grid_dim_y);
  assign lim_z = clamp_dim(grid_dim_z);

  // |point - origin| and its sign; both differences formed side by side
  function automatic logic [PT_W:0] abs_diff(input logic [PT_W-1:0] p,
                                             input logic [PT_W-1:0] o);
    logic [PT_W:0] d_po, d_op;
    d_po = {p[PT_W-1], p} - {o[PT_W-1], o};
    d_op = {o[PT_W-1], o} - {p[PT_W-1], p};
    return d_po[PT_W] ? {1'b1, d_op[PT_W-1:0]} : {1'b0, d_po[PT_W-1:0]};
  endfunction

  logic [PT_W-1:0] mag_x, mag_y, mag_z;
  logic            neg_x, neg_y, neg_z;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      {neg_x, mag_x} <= abs_diff(point_x, org_x);
      {neg_y, mag_y} <= abs_diff(point_y, org_y);
      {neg_z, mag_z} <= abs_diff(point_z, org_z);
    end
  end

  // shared scaler, one axis per pass
  logic [PT_W-1:0]        mag_sel;
  logic                   neg_sel;
  logic [LIM_W-1:0]       lim_sel;
  logic [PT_W+CFG_W-1:0]  prod;
  logic [PT_W-1:0]        q;

  always_comb begin
    unique case (cmd.axis)
      AXIS_X:  begin mag_sel = mag_x; neg_sel = neg_x; lim_sel = lim_x; end
      AXIS_Y:  begin mag_sel = mag_y; neg_sel = neg_y; lim_sel = lim_y; end
      AXIS_Z:  begin mag_sel = mag_z; neg_sel = neg_z; lim_sel = lim_z; end
      default: begin mag_sel = mag_z; neg_sel = neg_z; lim_sel = lim_z; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= (PT_W+CFG_W)'(mag_sel) * (PT_W+CFG_W)'(inv_size);
  end

  assign q       = prod[PT_W+CFG_W-1:CFG_W];
  // a negative offset survives only when it truncates to zero
  assign st.drop = (neg_sel && (q != '0)) || (q >= PT_W'(lim_sel));

  logic [COORD_W-1:0] crd_x, crd_y, crd_z;

  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      unique case (cmd.axis)
        AXIS_X:  crd_x <= q[COORD_W-1:0];
        AXIS_Y:  crd_y <= q[COORD_W-1:0];
        default: crd_z <= q[COORD_W-1:0];
      endcase
    end
  end

  // linear index in two steps
  logic [TF_W-1:0]      t_full;
  logic [2*COORD_W-1:0] t_zy;
  logic [IF_W-1:0]      idx_full;
  logic [IDX_W-1:0]     idx;

  assign t_full   = TF_W'(crd_z) * TF_W'(lim_y) + TF_W'(crd_y);
  assign idx_full = IF_W'(t_zy) * IF_W'(lim_x) + IF_W'(crd_x);

  always_ff @(posedge clk) begin
    if (cmd.idx1) t_zy <= t_full[2*COORD_W-1:0];
    if (cmd.idx2) idx  <= idx_full[IDX_W-1:0];
  end

  // count store
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data, cnt_inc, wdata;
  logic [ADDR_W-1:0]     addr, clr_addr;
  logic                  mem_we, sat;
  logic [THR_W-1:0]      thr;

  assign sat     = (rd_data == COUNT_MAX);
  assign cnt_inc = rd_data + COUNT_BITS'(1);
  assign thr     = (min_points == '0) ? THR_W'(1) : min_points;
  assign st.emit = !sat && (CMP_W'(cnt_inc) == CMP_W'(thr));

  assign mem_we = cmd.clr_step || (cmd.upd && !sat);
  assign addr   = cmd.clr_step ? clr_addr : idx[ADDR_W-1:0];
  assign wdata  = cmd.clr_step ? '0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= wdata;
    rd_data <= mem[addr];
  end

  assign st.clr_last = (clr_addr == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= st.clr_last ? '0 : clr_addr + ADDR_W'(1);
    end
  end

  // result register
  assign st.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      priority if (cmd.upd && st.emit) out_valid <= 1'b1;
      else if (out_ready)              out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && st.emit) begin
      voxel_x     <= crd_x;
      voxel_y     <= crd_y;
      voxel_z     <= crd_z;
      voxel_index <= idx;
    end
  end

  a_sat_no_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.upd && sat) |-> !mem_we)
    else $error("saturated counter written");

  a_update_nonzero: assert property (@(posedge clk) disable iff (rst)
    (mem_we && !cmd.clr_step) |-> (wdata != '0))
    else $error("count update wrote zero");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(voxel_index)))
    else $error("pending result changed before its transfer");

endmodule

### rtl/voxel_occupancy_counter.sv
// ----------------------------------------------------------------------------
// voxel_occupancy_counter
// Streams Q16.16 points into a voxel grid, counts points per voxel and
// reports each voxel once between clears, when its count first reaches min_points.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  req     | in  | valid/ready        | req_type, point_x, point_y, point_z
//  occ     | out | valid/ready        | voxel_x, voxel_y, voxel_z, voxel_index
//  cfg     | in  | cfg_we, no stall   | cfg_index, cfg_data
//
//  Add request: accept, then scale and range check for each axis on the one
//  shared 32x32 multiplier, 2 index steps, store read, write back; the next
//  request is taken after the write back, a result is registered at the
//  write back, and a point dropped on an axis frees the port earlier.
//  Clear request and reset: a clearing pass zeroes the count store one entry
//  a cycle, all MAX_DIM^3 (32768 by default), req not ready meanwhile.
//  A full occ register holds the write back until the result is taken, so a
//  stalled consumer stalls the request side after one pending result.
//  Register writes are taken at any cycle.
//
module voxel_occupancy_counter #(
  parameter int MAX_DIM    = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  voc_in_if.sink                    req,
  voc_out_if.source                 occ,
  input  logic                      cfg_we,
  input  voc_pkg::cfg_idx_t         cfg_index,
  input  logic [voc_pkg::CFG_W-1:0] cfg_data
);
  import voc_pkg::*;

  // voxel coordinate width follows the grid bound
  localparam int COORD_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  voc_cmd_t cmd;
  voc_sts_t st;

  // sequencer
  voc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .in_ready    (req.ready),
    .st          (st),
    .cmd         (cmd)
  );

  // arithmetic, count store and result register
  voc_dp #(
    .MAX_DIM    (MAX_DIM),
    .COUNT_BITS (COUNT_BITS),
    .COORD_W    (COORD_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_x     (req.point_x),
    .point_y     (req.point_y),
    .point_z     (req.point_z),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (occ.valid),
    .out_ready   (occ.ready),
    .voxel_x     (occ.voxel_x),
    .voxel_y     (occ.voxel_y),
    .voxel_z     (occ.voxel_z),
    .voxel_index (occ.voxel_index)
  );

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb - voxel occupancy counter testbench
// Streams add and clear requests into the counter under several register
// settings and both-sided stalls. An in-bench occupancy predictor holds its
// own count store and flags every voxel report that is wrong, missing or
// surplus. It also drives one voxel well past a raised threshold.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import voc_pkg::*;

  localparam int          GRID_MAX      = 32;
  localparam int          STORE_DEPTH   = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int unsigned COUNT_MAX     = 65535;
  localparam int          RUN_THRESHOLD = 40;         // raised threshold
  localparam int          RUN_HITS      = 48;         // a few past it
  localparam int          SETTLE_CYCLES = 16;         // longer than an add takes
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int          PRINT_CAP     = 40;

  typedef struct packed {
    logic [4:0]  x;
    logic [4:0]  y;
    logic [4:0]  z;
    logic [14:0] index;
  } voxel_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  cfg_idx_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  voc_in_if               req_if ();
  voc_out_if #(.COORD_W(5)) occ_if ();

  voxel_occupancy_counter u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .occ       (occ_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor's own copy of the register file and the count store.
  logic [31:0] org_x, org_y, org_z;
  logic [31:0] inv_q;
  logic [5:0]  dim_x, dim_y, dim_z;
  logic [15:0] min_pts;
  int unsigned voxel_count [STORE_DEPTH];

  voxel_t      pending_voxels [$];   // reports still owed by the block
  point_t      recent_pts [$];      // points worth hitting again

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          calm_left     = 0;   // cycles left in a no-stall stretch
  int          error_count   = 0;
  int          requests_sent = 0;
  int          clears_sent   = 0;
  int          clears_left   = 4;   // each clear costs a full store sweep
  int          settings_used = 0;
  int          voxels_seen   = 0;
  int unsigned cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One axis: exact 33-bit difference, exact product with the Q16.16
  // reciprocal, then truncation toward zero. A small negative difference
  // rounds to coordinate 0 and is kept.
  function automatic bit axis_voxel(input logic [31:0] p, input logic [31:0] org,
                                    input logic [5:0] dim, output logic [4:0] c);
    longint      diff;
    logic [63:0] mag;
    logic [63:0] scaled;
    int unsigned lim;
    diff   = longint'($signed(p)) - longint'($signed(org));
    mag    = (diff < 0) ? 64'(-diff) : 64'(diff);
    scaled = (mag * 64'(inv_q)) >> 32;
    lim    = (dim > 6'd32) ? 32 : int'(dim);   // oversize dims clamp
    c      = scaled[4:0];
    if (diff < 0 && scaled != 0)
      return 1'b0;
    return scaled < 64'(lim);
  endfunction

  // Applies one accepted request to the store; returns 1 with the voxel when
  // the count lands exactly on the threshold.
  function automatic bit predict_occupancy(input logic kind, input point_t pt,
                                           output voxel_t v);
    logic [4:0]  cx, cy, cz;
    int unsigned gx, gy, idx, thr;
    v = '0;
    if (kind == REQ_CLEAR) begin
      foreach (voxel_count[i]) voxel_count[i] = 0;
      return 1'b0;
    end
    if (!axis_voxel(pt.x, org_x, dim_x, cx)) return 1'b0;
    if (!axis_voxel(pt.y, org_y, dim_y, cy)) return 1'b0;
    if (!axis_voxel(pt.z, org_z, dim_z, cz)) return 1'b0;
    gx  = (dim_x > 6'd32) ? 32 : int'(dim_x);
    gy  = (dim_y > 6'd32) ? 32 : int'(dim_y);
    idx = int'(cz) * gx * gy + int'(cy) * gx + int'(cx);
    if (voxel_count[idx] >= COUNT_MAX)
      return 1'b0;                              // saturated: silent
    voxel_count[idx]++;
    thr = (min_pts == 0) ? 1 : int'(min_pts);   // zero threshold acts as one
    if (voxel_count[idx] != thr)
      return 1'b0;
    v.x     = cx;
    v.y     = cy;
    v.z     = cz;
    v.index = idx[14:0];
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Sender gaps first, then hold the request until its transfer. valid is
  // left high on return so back-to-back requests need no second assignment.
  task automatic send_request(input logic kind, input logic [31:0] px,
                              input logic [31:0] py, input logic [31:0] pz);
    voxel_t v;
    point_t pt;
    pt = '{px, py, pz};
    while (calm_left == 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.point_x  <= px;
    req_if.point_y  <= py;
    req_if.point_z  <= pz;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    requests_sent++;
    if (kind == REQ_CLEAR)
      clears_sent++;
    if (predict_occupancy(kind, pt, v))
      pending_voxels.insert(pending_voxels.size(), v);
  endtask

  // Drop valid, let every owed report out, give a dropped point time to
  // leave the pipeline and wait out a clearing pass before anything touches
  // the registers.
  task automatic settle_block();
    req_if.valid <= 1'b0;
    while (pending_voxels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
  endtask

  // One register write, then a quiet cycle so cfg_we never toggles twice in
  // a step.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_ORIGIN_X:   org_x   = data;
      REG_ORIGIN_Y:   org_y   = data;
      REG_ORIGIN_Z:   org_z   = data;
      REG_INV_VOXEL:  inv_q   = data;
      REG_GRID_DIM_X: dim_x   = data[5:0];
      REG_GRID_DIM_Y: dim_y   = data[5:0];
      REG_GRID_DIM_Z: dim_z   = data[5:0];
      REG_MIN_POINTS: min_pts = data[15:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_geometry(input logic [31:0] ox, input logic [31:0] oy,
                                input logic [31:0] oz, input logic [31:0] inv,
                                input logic [31:0] dims, input logic [31:0] thr);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_INV_VOXEL, inv);
    write_reg(REG_GRID_DIM_X, dims);
    write_reg(REG_GRID_DIM_Y, dims);
    write_reg(REG_GRID_DIM_Z, dims);
    write_reg(REG_MIN_POINTS, thr);
    settings_used++;
  endtask

  // Mostly small grids so that repeats build counts; upper data bits carry
  // junk that the block has to mask off.
  function automatic logic [31:0] pick_dim();
    logic [5:0] d;
    d = ($urandom_range(2) == 0) ? 6'($urandom_range(32, 1))
                                 : 6'($urandom_range(6, 1));
    return {26'($urandom), d};
  endfunction

  task automatic apply_random_setting();
    logic [31:0] inv;
    case ($urandom_range(3))
      0:       inv = 32'h0001_0000;
      1:       inv = 32'h1 << $urandom_range(22, 10);
      2:       inv = $urandom_range(32'h0010_0000, 32'h0000_1000);
      default: inv = $urandom | 32'h1;
    endcase
    write_reg(REG_ORIGIN_X, $urandom);
    write_reg(REG_ORIGIN_Y, $urandom);
    write_reg(REG_ORIGIN_Z, $urandom);
    write_reg(REG_INV_VOXEL, inv);
    write_reg(REG_GRID_DIM_X, pick_dim());
    write_reg(REG_GRID_DIM_Y, pick_dim());
    write_reg(REG_GRID_DIM_Z, pick_dim());
    write_reg(REG_MIN_POINTS,
              {16'($urandom), 16'(($urandom_range(2) == 0) ? 1 : $urandom_range(4, 1))});
    settings_used++;
  endtask

  // Coordinate that mostly lands inside the grid on this axis; now and then
  // a little below the origin, which straddles the keep/drop boundary.
  function automatic logic [31:0] pick_axis(input logic [31:0] org, input logic [5:0] dim);
    logic [63:0] span;
    logic [63:0] vox_w;
    logic [63:0] below;
    int unsigned lim;
    lim   = (dim > 6'd32) ? 32 : ((dim == 0) ? 1 : int'(dim));
    span  = (64'(lim) << 32) / 64'(inv_q);
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    vox_w = span / lim;
    below = (vox_w << 1) > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : (vox_w << 1);
    if ($urandom_range(7) == 0)
      return org - $urandom_range(below[31:0], 0);
    return org + $urandom_range(span[31:0], 0);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset geometry: unit voxels, 32^3 grid, threshold one.
  task automatic test_default_grid();
    send_request(REQ_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_ADD, 32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF);  // far corner
    send_request(REQ_ADD, 32'h0020_0000, 32'h0000_0000, 32'h0000_0000);  // one past x
    send_request(REQ_ADD, 32'hFFFF_FFFF, 32'h0005_0000, 32'h0000_0000);  // tiny negative kept
    send_request(REQ_ADD, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000);  // -1.0 dropped
    send_request(REQ_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(REQ_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // second hit, silent
    send_request(REQ_CLEAR, $urandom, $urandom, $urandom);
    send_request(REQ_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // reported again
  endtask

  // Counts stay at their linear address when the geometry changes; odd
  // dimension and threshold values.
  task automatic test_linear_addressing();
    settle_block();
    write_reg(REG_MIN_POINTS, 32'd2);
    send_request(REQ_ADD, 32'h0002_0000, 32'h0001_0000, 32'h0000_0000);  // index 34
    settle_block();
    write_reg(REG_GRID_DIM_X, 32'd16);
    send_request(REQ_ADD, 32'h0002_0000, 32'h0002_0000, 32'h0000_0000);  // index 34 again
    settle_block();
    write_reg(REG_GRID_DIM_Z, 32'd0);                                    // drops everything
    send_request(REQ_ADD, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
    settle_block();
    write_reg(REG_GRID_DIM_X, 32'hFFFF_FFFF);                            // 63: clamps to 32
    write_reg(REG_GRID_DIM_Y, 32'hFFFF_FFFF);
    write_reg(REG_GRID_DIM_Z, 32'hFFFF_FFFF);
    write_reg(REG_MIN_POINTS, 32'hFFFF_0000);                            // zero threshold
    send_request(REQ_ADD, 32'h001F_8000, 32'h001F_8000, 32'h001F_8000);
    settle_block();
    write_geometry(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'd1, 32'd1);    // single voxel
    send_request(REQ_ADD, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_request(REQ_ADD, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
  endtask

  // Origin and reciprocal at their limits, where the 33-bit difference and
  // the full 64-bit product matter.
  task automatic test_register_extremes();
    settle_block();
    write_geometry(32'h8000_0000, 32'h7FFF_FFFF, $urandom, 32'h1, 32'd32, 32'd1);
    send_request(REQ_ADD, 32'h7FFF_FFFF, 32'h8000_0000, $urandom);
    send_request(REQ_ADD, $urandom, $urandom, $urandom);
    settle_block();
    write_geometry(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'd32, 32'd1);
    send_request(REQ_ADD, 32'd31, 32'd30, 32'd1);
    send_request(REQ_ADD, 32'd32, 32'd32, 32'd32);
    send_request(REQ_ADD, 32'd33, 32'd0, 32'd0);
    settle_block();
    write_reg(REG_ORIGIN_X, 32'h7FFF_FFFF);
    send_request(REQ_ADD, 32'h8000_0000, 32'd0, 32'd0);
  endtask

  // Random traffic: mostly points inside the grid, repeats to drive counts
  // to the threshold, a share of raw noise and the odd store clear.
  task automatic test_random_stream(input int n_settings, input int n_items);
    point_t pt;
    int     pick;
    for (int s = 0; s < n_settings; s++) begin
      settle_block();
      apply_random_setting();
      recent_pts.delete();
      for (int i = 0; i < n_items; i++) begin
        pick = $urandom_range(199);
        if (pick == 0 && clears_left > 0) begin
          clears_left--;
          send_request(REQ_CLEAR, $urandom, $urandom, $urandom);
        end else if (pick < 30) begin
          send_request(REQ_ADD, $urandom, $urandom, $urandom);
        end else if (pick < 100 && recent_pts.size() != 0) begin
          pt = recent_pts[$urandom_range(recent_pts.size() - 1)];
          send_request(REQ_ADD, pt.x, pt.y, pt.z);
        end else begin
          pt.x = pick_axis(org_x, dim_x);
          pt.y = pick_axis(org_y, dim_y);
          pt.z = pick_axis(org_z, dim_z);
          recent_pts.insert(recent_pts.size(), pt);
          if (recent_pts.size() > 12)
            void'(recent_pts.pop_front());
          send_request(REQ_ADD, pt.x, pt.y, pt.z);
        end
      end
    end
  endtask

  // Raised threshold: one report on the exact hit, silence on the hits after.
  task automatic test_threshold_run();
    settle_block();
    write_geometry(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'd32, 32'(RUN_THRESHOLD));
    send_request(REQ_CLEAR, $urandom, $urandom, $urandom);
    repeat (RUN_HITS)
      send_request(REQ_ADD, 32'h0007_8000, 32'h0003_4000, 32'h0009_0000);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("[%0t] occupancy mismatch: %s", $realtime, msg);
  endtask

  // Random sink stalls, broken up by stretches where neither side idles.
  always @(posedge clk) begin
    if (calm_left != 0)
      calm_left <= calm_left - 1;
    else if ($urandom_range(199) == 0)
      calm_left <= $urandom_range(80, 30);
    occ_if.ready <= (calm_left != 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Every transfer on the result side is matched against the oldest report
  // owed.
  always @(posedge clk) begin : check_occupancy
    voxel_t want;
    if (!rst && occ_if.valid === 1'b1 && occ_if.ready === 1'b1) begin
      voxels_seen++;
      if (pending_voxels.size() == 0) begin
        flag_mismatch($sformatf("surplus voxel (%0d,%0d,%0d) index %0d",
                                occ_if.voxel_x, occ_if.voxel_y, occ_if.voxel_z,
                                occ_if.voxel_index));
      end else begin
        want = pending_voxels.pop_front();
        if (occ_if.voxel_x !== want.x)
          flag_mismatch($sformatf("voxel_x %0d, want %0d", occ_if.voxel_x, want.x));
        if (occ_if.voxel_y !== want.y)
          flag_mismatch($sformatf("voxel_y %0d, want %0d", occ_if.voxel_y, want.y));
        if (occ_if.voxel_z !== want.z)
          flag_mismatch($sformatf("voxel_z %0d, want %0d", occ_if.voxel_z, want.z));
        if (occ_if.voxel_index !== want.index)
          flag_mismatch($sformatf("voxel_index %0d, want %0d",
                                  occ_if.voxel_index, want.index));
      end
    end
  end

  // Watchdog; generous against the store sweeps and stalled traffic.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d reports still owed",
               cycle_count, pending_voxels.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_ORIGIN_X;
    cfg_data        = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_ADD;
    req_if.point_x  = '0;
    req_if.point_y  = '0;
    req_if.point_z  = '0;
    occ_if.ready    = 1'b0;
    // predictor mirrors the reset register values and an empty store
    org_x   = '0;
    org_y   = '0;
    org_z   = '0;
    inv_q   = 32'h0001_0000;
    dim_x   = 6'd32;
    dim_y   = 6'd32;
    dim_z   = 6'd32;
    min_pts = 16'd1;
    foreach (voxel_count[i]) voxel_count[i] = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // sender light, sink heavy
    set_idling(17, 56);
    test_default_grid();
    test_linear_addressing();
    test_register_extremes();
    test_random_stream(3, 120);
    // sender heavy, sink light
    set_idling(56, 17);
    test_random_stream(3, 120);
    // full rate both sides
    set_idling(0, 0);
    test_random_stream(3, 120);
    test_threshold_run();
    settle_block();

    $display("%0d requests (%0d store clears), %0d register settings, %0d reports checked",
             requests_sent, clears_sent, settings_used, voxels_seen);
    $display("covered grid edges, negative rounding, clamped dims, zero and raised thresholds");
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
